### rtl/txcon_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txcon_pkg
// Shared types and constants for the text console writer: transaction
// payloads, cell constants and sequencer states.
// ----------------------------------------------------------------------------
package txcon_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int CURSOR_W = 11;
	localparam int INDEX_W  = 11;
	localparam int BYTE_W   = 8;
	localparam int CELL_W   = 2 * BYTE_W;

	localparam logic [BYTE_W-1:0] BLANK_CHAR   = 8'h20;
	localparam logic [BYTE_W-1:0] BLANK_ATTR   = 8'h07;
	localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0A;

	localparam logic ACT_PUT  = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef struct packed {
		logic                action;
		logic [BYTE_W-1:0]   character;
		logic [BYTE_W-1:0]   colour;
		logic [INDEX_W-1:0]  cell_index;
	} txcon_in_t;

	typedef struct packed {
		logic [CURSOR_W-1:0] cursor_position;
		logic                scrolled;
		logic [BYTE_W-1:0]   read_char;
		logic [BYTE_W-1:0]   read_attr;
	} txcon_out_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_BLANK
	} txcon_state_t;

endpackage

### rtl/txcon_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txcon_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module txcon_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/text_console_writer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_top
// Character-cell text console: cursor tracking, screen store, scrolling and
// cell readback.
// ----------------------------------------------------------------------------
// After reset the block sweeps the screen store to blank cells (space, 0x07),
// one cell per cycle, so in_ready stays low until all ROWS*COLUMNS cells
// (2000 at 80x25) are blank. A put that does not scroll is finished in the
// idle state. A read passes through a read state for the registered read of
// the screen RAM. A put that scrolls then blanks a row: rows are kept in a
// circular order behind a top-row base, so a scroll only blanks one row, one
// cell per cycle through the single RAM write port. One shared address adder
// maps screen positions onto RAM addresses for every access. A finished
// result sits in an output register; the next transaction is taken once that
// register is free or being emptied.
module text_console_writer_top
	import txcon_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  txcon_in_t  in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output txcon_out_t out_item
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int WIDE_W = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;
	localparam int SUM_W  = ADDR_W + 1;

	localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
	localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(COLUMNS);
	localparam logic [SUM_W-1:0]  CELLS_SUM  = SUM_W'(CELLS);
	localparam logic [WIDE_W-1:0] CELLS_WIDE = WIDE_W'(CELLS);
	localparam logic [WIDE_W-1:0] BOTTOM_POS = WIDE_W'((ROWS - 1) * COLUMNS);

	txcon_state_t state_q, state_nx;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] lin_q;       // cursor as row*COLUMNS+col
	logic [ADDR_W-1:0] row_base_q;  // row*COLUMNS
	logic [ADDR_W-1:0] top_base_q;  // ram address of the top screen row
	logic [ADDR_W-1:0] clr_q;
	logic [COL_W-1:0]  bcol_q;
	logic              rd_ok_q;
	logic              out_valid_q;
	txcon_out_t        out_q;

	logic                accept;
	logic                is_put;
	logic                is_nl;
	logic                advance;
	logic                wrap;
	logic                out_set;
	logic [COL_W-1:0]    col_nx;
	logic [ROW_W-1:0]    row_nx;
	logic [ADDR_W-1:0]   lin_nx;
	logic [ADDR_W-1:0]   row_base_nx;
	logic [WIDE_W-1:0]   idx_wide;
	logic                idx_ok;
	logic [WIDE_W-1:0]   lin_wide;
	logic [WIDE_W-1:0]   lin_nx_wide;
	logic [SUM_W-1:0]    top_sum;

	// shared address unit
	logic [ADDR_W-1:0]   op_a;
	logic [SUM_W-1:0]    addr_sum;
	logic [ADDR_W-1:0]   phys_addr;

	logic                ram_we;
	logic [CELL_W-1:0]   ram_wdata;
	logic [CELL_W-1:0]   ram_rdata;

	assign accept   = in_valid && in_ready;
	assign is_put   = in_item.action == ACT_PUT;
	assign is_nl    = in_item.character == NEWLINE_CHAR;
	assign advance  = is_put && (is_nl || col_q == COL_LAST);
	assign wrap     = advance && row_q == ROW_LAST;
	assign idx_wide = WIDE_W'(in_item.cell_index);
	assign idx_ok   = idx_wide < CELLS_WIDE;
	assign lin_wide = WIDE_W'(lin_q);
	assign lin_nx_wide = WIDE_W'(lin_nx);
	assign top_sum  = SUM_W'(top_base_q) + SUM_W'(ROW_STEP);

	// a result is finished this cycle
	assign out_set = (state_q == ST_IDLE && accept && is_put && !wrap) ||
	                 (state_q == ST_READ) ||
	                 (state_q == ST_BLANK && bcol_q == COL_LAST);

	assign addr_sum  = SUM_W'(op_a) + SUM_W'(top_base_q);
	assign phys_addr = (addr_sum >= CELLS_SUM) ? ADDR_W'(addr_sum - CELLS_SUM)
	                                           : ADDR_W'(addr_sum);

	// cursor update for a put
	always_comb begin
		col_nx      = col_q + COL_W'(1);
		row_nx      = row_q;
		lin_nx      = lin_q + ADDR_W'(1);
		row_base_nx = row_base_q;
		if (wrap) begin
			col_nx = '0;
			lin_nx = row_base_q;
		end else if (advance) begin
			col_nx      = '0;
			row_nx      = row_q + ROW_W'(1);
			lin_nx      = row_base_q + ROW_STEP;
			row_base_nx = row_base_q + ROW_STEP;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == CELL_LAST) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (!is_put) begin
						state_nx = ST_READ;
					end else if (wrap) begin
						state_nx = ST_BLANK;
					end
				end
			end
			ST_READ: begin
				state_nx = ST_IDLE;
			end
			ST_BLANK: begin
				if (bcol_q == COL_LAST) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		op_a      = lin_q;
		ram_wdata = {BLANK_ATTR, BLANK_CHAR};
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				op_a   = clr_q;
			end
			ST_IDLE: begin
				in_ready  = !out_valid_q || out_ready;
				op_a      = is_put ? lin_q : idx_wide[ADDR_W-1:0];
				ram_we    = accept && is_put && !is_nl;
				ram_wdata = {in_item.colour, in_item.character};
			end
			ST_READ: begin
				ram_we = 1'b0;
			end
			ST_BLANK: begin
				ram_we = 1'b1;
				op_a   = ADDR_W'(bcol_q);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			col_q       <= '0;
			row_q       <= '0;
			lin_q       <= '0;
			row_base_q  <= '0;
			top_base_q  <= '0;
			clr_q       <= '0;
			bcol_q      <= '0;
			rd_ok_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nx;
			out_valid_q <= out_set || (out_valid_q && !out_ready);
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
				end
				ST_IDLE: begin
					if (accept) begin
						rd_ok_q <= idx_ok;
						if (is_put) begin
							col_q      <= col_nx;
							row_q      <= row_nx;
							lin_q      <= lin_nx;
							row_base_q <= row_base_nx;
							bcol_q     <= '0;
						end
					end
				end
				ST_READ: begin
					rd_ok_q <= rd_ok_q;
				end
				ST_BLANK: begin
					bcol_q <= bcol_q + COL_W'(1);
					if (bcol_q == COL_LAST) begin
						top_base_q <= (top_sum >= CELLS_SUM) ? '0 : ADDR_W'(top_sum);
					end
				end
				default: begin
					rd_ok_q <= 1'b0;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept && is_put && !wrap) begin
					out_q.cursor_position <= lin_nx_wide[CURSOR_W-1:0];
					out_q.scrolled        <= 1'b0;
					out_q.read_char       <= '0;
					out_q.read_attr       <= '0;
				end
			end
			ST_READ: begin
				out_q.cursor_position <= lin_wide[CURSOR_W-1:0];
				out_q.scrolled        <= 1'b0;
				out_q.read_char       <= rd_ok_q ? ram_rdata[BYTE_W-1:0] : '0;
				out_q.read_attr       <= rd_ok_q ? ram_rdata[CELL_W-1:BYTE_W] : '0;
			end
			ST_BLANK: begin
				if (bcol_q == COL_LAST) begin
					out_q.cursor_position <= lin_wide[CURSOR_W-1:0];
					out_q.scrolled        <= 1'b1;
					out_q.read_char       <= '0;
					out_q.read_attr       <= '0;
				end
			end
			default: begin
				out_q <= out_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	txcon_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_screen_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (phys_addr),
		.wdata (ram_wdata),
		.raddr (phys_addr),
		.rdata (ram_rdata)
	);

	// cursor registers stay consistent with each other
	a_lin_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		lin_q == row_base_q + ADDR_W'(col_q))
		else $error("cursor linear position out of step with row and column");

	a_top_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		WIDE_W'(top_base_q) < CELLS_WIDE)
		else $error("top row base outside the screen store");

	a_scroll_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.scrolled |->
			out_item.cursor_position == BOTTOM_POS[CURSOR_W-1:0])
		else $error("scrolled transaction does not report bottom row start");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BLANK || state_q == ST_READ || state_q == ST_CLEAR) |-> !in_ready)
		else $error("input taken while the sequencer is busy");

	a_result_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |=> out_valid_q)
		else $error("read transaction produced no result");

endmodule

### tb/sv/text_console_writer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_top_test
// Self-checking bench for the text console writer. A mirror of the screen
// and cursor predicts the cursor report, scroll flag and cell readback of
// every transaction. Directed puts, newlines and reads come first. Random
// text with wrapping runs and scrolls follows, mixed with cell reads.
// Both channels idle at random. There is one long receiver hold-off and one
// full drain of the sender.
// ----------------------------------------------------------------------------
module text_console_writer_top_test;
	import txcon_pkg::*;

	localparam int COLUMNS     = COLUMNS_DEF;
	localparam int ROWS        = ROWS_DEF;
	localparam int CELLS       = COLUMNS * ROWS;
	localparam int IDLE_PCT    = 28;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_REPORTS = 10;

	localparam logic [CELL_W-1:0] BLANK_CELL = {BLANK_ATTR, BLANK_CHAR};

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	txcon_in_t  in_item   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	txcon_out_t out_item;

	txcon_in_t  text_stream_q[$];
	txcon_out_t cursor_report_q[$];

	logic [CELL_W-1:0] screen_mirror [CELLS];
	int unsigned       cur_col;
	int unsigned       cur_row;

	int error_cnt   = 0;
	int sent_cnt    = 0;
	int got_cnt     = 0;
	int hold_left   = 0;
	bit hold_done   = 1'b0;
	int idle_cycles = 0;

	always #4 clk = ~clk;

	text_console_writer_top #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	// update the screen mirror and return the report for one transaction
	function automatic txcon_out_t console_step(input txcon_in_t it);
		txcon_out_t res;
		res = '0;
		if (it.action == ACT_READ) begin
			if (it.cell_index < CELLS) begin
				res.read_char = screen_mirror[it.cell_index][BYTE_W-1:0];
				res.read_attr = screen_mirror[it.cell_index][CELL_W-1:BYTE_W];
			end
		end else begin
			if (it.character == NEWLINE_CHAR) begin
				cur_col = 0;
				cur_row++;
			end else begin
				screen_mirror[cur_row * COLUMNS + cur_col] = {it.colour, it.character};
				cur_col++;
				if (cur_col >= COLUMNS) begin
					cur_col = 0;
					cur_row++;
				end
			end
			if (cur_row >= ROWS) begin
				for (int i = 0; i < CELLS - COLUMNS; i++)
					screen_mirror[i] = screen_mirror[i + COLUMNS];
				for (int i = CELLS - COLUMNS; i < CELLS; i++)
					screen_mirror[i] = BLANK_CELL;
				cur_row      = ROWS - 1;
				res.scrolled = 1'b1;
			end
		end
		res.cursor_position = CURSOR_W'(cur_row * COLUMNS + cur_col);
		return res;
	endfunction

	function automatic txcon_in_t put_item(input logic [BYTE_W-1:0] ch,
			input logic [BYTE_W-1:0] attr);
		txcon_in_t it;
		it.action     = ACT_PUT;
		it.character  = ch;
		it.colour     = attr;
		it.cell_index = INDEX_W'($urandom);
		return it;
	endfunction

	function automatic txcon_in_t read_item(input int idx);
		txcon_in_t it;
		it.action     = ACT_READ;
		it.character  = BYTE_W'($urandom);
		it.colour     = BYTE_W'($urandom);
		it.cell_index = INDEX_W'(idx);
		return it;
	endfunction

	function automatic txcon_in_t random_item();
		int pick;
		int zone;
		pick = $urandom_range(99);
		zone = $urandom_range(9);
		if (pick < 9)
			return put_item(NEWLINE_CHAR, BYTE_W'($urandom));
		else if (pick < 56)
			return put_item(BYTE_W'($urandom), BYTE_W'($urandom));
		else if (zone == 0)
			return read_item($urandom_range((1 << INDEX_W) - 1, CELLS));
		else if (zone < 4)
			return read_item($urandom_range(CELLS - 1, CELLS - 2 * COLUMNS));
		else
			return read_item($urandom_range(CELLS - 1, 0));
	endfunction

	task automatic note_error(input string msg);
		error_cnt++;
		if (error_cnt <= MAX_REPORTS)
			$display("%s", msg);
	endtask

	// driver: offers queued transactions, predicts each one on acceptance
	always @(posedge clk or negedge arst_n) begin : drive_proc
		logic stuck;
		bit   quiet;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
		end else begin
			stuck = in_valid && !in_ready;
			if (in_valid && in_ready) begin
				cursor_report_q.push_back(console_step(in_item));
				sent_cnt++;
			end
			quiet = (sent_cnt >= 700) && (sent_cnt < 1000);
			if (!stuck) begin
				if (text_stream_q.size() != 0 &&
						(quiet || $urandom_range(99) >= IDLE_PCT)) begin
					in_item  <= text_stream_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver back-pressure, with one long hold-off
	always @(posedge clk or negedge arst_n) begin : ready_proc
		bit quiet;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			quiet = (got_cnt >= 720) && (got_cnt < 1020);
			if (!hold_done && got_cnt >= 250) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// monitor: compare each accepted result with the oldest prediction
	always @(posedge clk) begin : monitor_proc
		txcon_out_t want;
		if (arst_n && out_valid && out_ready) begin
			got_cnt++;
			if (cursor_report_q.size() == 0) begin
				note_error($sformatf("unexpected transaction: cursor %0d scrolled %0b char %02h attr %02h",
					out_item.cursor_position, out_item.scrolled,
					out_item.read_char, out_item.read_attr));
			end else begin
				want = cursor_report_q.pop_front();
				if (out_item.cursor_position !== want.cursor_position ||
						out_item.scrolled !== want.scrolled ||
						out_item.read_char !== want.read_char ||
						out_item.read_attr !== want.read_attr)
					note_error($sformatf({"mismatch on result %0d: expected cursor %0d ",
						"scrolled %0b char %02h attr %02h, got cursor %0d scrolled %0b ",
						"char %02h attr %02h"}, got_cnt,
						want.cursor_position, want.scrolled, want.read_char,
						want.read_attr, out_item.cursor_position, out_item.scrolled,
						out_item.read_char, out_item.read_attr));
			end
		end
	end

	// watchdog on cycles without any accepted transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("text_console_writer_top_test: done, errors");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < CELLS; i++)
			screen_mirror[i] = BLANK_CELL;
		cur_col = 0;
		cur_row = 0;

		// blank screen corners and out-of-range reads
		text_stream_q.push_back(read_item(0));
		text_stream_q.push_back(read_item(CELLS - 1));
		text_stream_q.push_back(read_item(CELLS));
		text_stream_q.push_back(read_item((1 << INDEX_W) - 1));
		// byte extremes, a newline that writes nothing, control bytes
		text_stream_q.push_back(put_item(8'h41, 8'h1F));
		text_stream_q.push_back(put_item(8'h00, 8'h00));
		text_stream_q.push_back(put_item(8'hFF, 8'hFF));
		text_stream_q.push_back(put_item(NEWLINE_CHAR, 8'hFF));
		text_stream_q.push_back(put_item(8'h0B, 8'h80));
		text_stream_q.push_back(put_item(BLANK_CHAR, BLANK_ATTR));
		text_stream_q.push_back(put_item(8'h09, 8'h4E));
		for (int i = 0; i < 4; i++)
			text_stream_q.push_back(read_item(i));
		for (int i = 0; i < 4; i++)
			text_stream_q.push_back(read_item(COLUMNS + i));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < 500; i++)
			text_stream_q.push_back(random_item());
		// long unbroken text so rows wrap and scroll without newlines
		for (int i = 0; i < 180; i++)
			text_stream_q.push_back(put_item(BYTE_W'($urandom_range(255, 11)),
				BYTE_W'($urandom)));

		// sender pause until the block has returned everything
		while (text_stream_q.size() != 0 || in_valid || cursor_report_q.size() != 0)
			@(posedge clk);

		for (int i = 0; i < 870; i++)
			text_stream_q.push_back(random_item());

		while (text_stream_q.size() != 0 || in_valid)
			@(posedge clk);
		while (cursor_report_q.size() != 0)
			@(posedge clk);
		repeat (4 * COLUMNS) @(posedge clk);

		if (error_cnt == 0 && cursor_report_q.size() == 0)
			$display("text_console_writer_top_test: done, clean");
		else
			$display("text_console_writer_top_test: done, errors");
		$finish;
	end

endmodule

### sim.f
rtl/txcon_pkg.sv
rtl/txcon_ram.sv
rtl/text_console_writer_top.sv
tb/sv/text_console_writer_top_test.sv
